// ----- hdl/ldcd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ldcd_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CMD   = 2'd1,
    OP_DATA  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RPT_DATA_CMD = 3'd0,
    RPT_DISP_CMD = 3'd1,
    RPT_ADDR_CMD = 3'd2,
    RPT_DIGIT    = 3'd3,
    RPT_TEXT     = 3'd4
  } report_kind_t;

  localparam logic [1:0] CMD_TOP_DATA = 2'b01;
  localparam logic [1:0] CMD_TOP_DISP = 2'b10;
  localparam logic [1:0] CMD_TOP_ADDR = 2'b11;

  localparam logic [1:0] PM_NONE  = 2'd0;
  localparam logic [1:0] PM_DOT   = 2'd1;
  localparam logic [1:0] PM_COLON = 2'd2;

  localparam logic [6:0] CHAR_DOT     = 7'h2E;
  localparam logic [6:0] CHAR_COLON   = 7'h3A;
  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;

  localparam logic [3:0] POS_MAX = 4'hF;

  localparam int FONT_SIZE = 35;

  localparam logic [6:0] GLYPH_SEGS [FONT_SIZE] = '{
    7'h00, 7'h20, 7'h40, 7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F,
    7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h76, 7'h30, 7'h0E, 7'h38, 7'h54,
    7'h5C, 7'h73, 7'h50, 7'h78, 7'h3E, 7'h0F, 7'h08, 7'h58, 7'h74, 7'h10, 7'h1C
  };

  localparam logic [6:0] GLYPH_CHARS [FONT_SIZE] = '{
    7'h20, 7'h27, 7'h2D, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h41, 7'h62, 7'h43, 7'h64, 7'h45, 7'h46, 7'h48, 7'h49, 7'h4A, 7'h4C, 7'h6E,
    7'h6F, 7'h50, 7'h72, 7'h74, 7'h55, 7'h5D, 7'h5F, 7'h63, 7'h68, 7'h69, 7'h75
  };

  typedef struct packed {
    report_kind_t kind;
    logic [7:0]   data;
    logic [6:0]   glyph;
    logic [1:0]   point_mark;
  } ldcd_item_t;

  typedef struct packed {
    report_kind_t kind;
    logic         test_mode;
    logic         fixed_addressing;
    logic         read_access;
    logic         display_on;
    logic [2:0]   contrast_level;
    logic [3:0]   digit_position;
    logic [7:0]   segment_mask;
    logic [6:0]   char_code;
    logic [1:0]   point_mark;
    logic         last;
  } ldcd_result_t;

  function automatic logic [6:0] glyph_of(input logic [6:0] segs);
    logic [6:0] ch;
    ch = CHAR_UNKNOWN;
    for (int i = FONT_SIZE - 1; i >= 0; i--) begin
      if (GLYPH_SEGS[i] == segs) begin
        ch = GLYPH_CHARS[i];
      end
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ldcd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ldcd_front
  import ldcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       point_as_colon,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic [1:0] in_tuser,
  input  wire logic       q_full,
  output logic            push,
  output ldcd_item_t      push_item
);

  logic       valid_r, valid_nxt;
  ldcd_item_t item_r;
  ldcd_item_t cls_item;
  logic       cls_valid;
  logic       take;

  always_comb begin
    cls_valid        = 1'b0;
    cls_item         = '0;
    cls_item.data    = in_tdata;
    cls_item.glyph   = glyph_of(in_tdata[6:0]);
    cls_item.point_mark = in_tdata[7] ? (point_as_colon ? PM_COLON : PM_DOT) : PM_NONE;
    case (in_tuser)
      OP_CMD: begin
        case (in_tdata[7:6])
          CMD_TOP_DATA: begin
            cls_valid     = 1'b1;
            cls_item.kind = RPT_DATA_CMD;
          end
          CMD_TOP_DISP: begin
            cls_valid     = 1'b1;
            cls_item.kind = RPT_DISP_CMD;
          end
          CMD_TOP_ADDR: begin
            cls_valid     = 1'b1;
            cls_item.kind = RPT_ADDR_CMD;
          end
          default: begin
            cls_valid = 1'b0;
          end
        endcase
      end
      OP_DATA: begin
        cls_valid     = 1'b1;
        cls_item.kind = RPT_DIGIT;
      end
      OP_STOP: begin
        cls_valid     = 1'b1;
        cls_item.kind = RPT_TEXT;
      end
      default: begin
        cls_valid = 1'b0;
      end
    endcase
  end

  assign in_tready = !valid_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign push      = valid_r && !q_full;
  assign push_item = item_r;
  assign valid_nxt = take ? cls_valid : (valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= cls_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ldcd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ldcd_queue
  import ldcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  ldcd_item_t      push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output ldcd_item_t      head
);

  ldcd_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ldcd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ldcd_back
  import ldcd_pkg::*;
#(
  parameter int TEXT_DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  ldcd_item_t head,
  output logic       pop,
  input  wire logic  out_ready,
  output logic       out_valid,
  output ldcd_result_t out_result
);

  localparam int AW = $clog2(TEXT_DEPTH);
  localparam int LW = $clog2(TEXT_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POINT,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } state_t;

  state_t       state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  ldcd_result_t res_r, res_nxt;
  logic         auto_r, auto_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [6:0]   point_char_r, point_char_nxt;

  logic [6:0]   text_mem [TEXT_DEPTH];
  logic [6:0]   rd_data_r;
  logic         mem_we;
  logic [6:0]   mem_wdata;
  logic         out_free;
  logic         store_full;
  logic         drain_last;

  assign out_free   = !out_valid_r || out_ready;
  assign store_full = (len_r == LW'(TEXT_DEPTH));
  assign drain_last = ((LW'(idx_r) + LW'(1)) == len_r);
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    res_nxt        = res_r;
    auto_nxt       = auto_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    point_char_nxt = point_char_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = head.glyph;
    case (state_r)
      ST_IDLE: begin
        if (head_valid && out_free) begin
          pop     = 1'b1;
          res_nxt = '0;
          res_nxt.kind = head.kind;
          res_nxt.last = 1'b1;
          case (head.kind)
            RPT_DATA_CMD: begin
              out_valid_nxt            = 1'b1;
              res_nxt.test_mode        = head.data[3];
              res_nxt.fixed_addressing = head.data[2];
              res_nxt.read_access      = head.data[1];
              auto_nxt                 = ~head.data[2];
            end
            RPT_DISP_CMD: begin
              out_valid_nxt          = 1'b1;
              res_nxt.display_on     = head.data[3];
              res_nxt.contrast_level = head.data[2:0];
            end
            RPT_ADDR_CMD: begin
              out_valid_nxt          = 1'b1;
              pos_nxt                = {1'b0, head.data[2:0]} + 4'd1;
              res_nxt.digit_position = {1'b0, head.data[2:0]} + 4'd1;
            end
            RPT_DIGIT: begin
              out_valid_nxt          = 1'b1;
              res_nxt.digit_position = pos_r;
              res_nxt.segment_mask   = head.data;
              res_nxt.char_code      = head.glyph;
              res_nxt.point_mark     = head.point_mark;
              if (!store_full) begin
                mem_we  = 1'b1;
                len_nxt = len_r + LW'(1);
              end
              if (head.point_mark != PM_NONE) begin
                point_char_nxt = (head.point_mark == PM_COLON) ? CHAR_COLON : CHAR_DOT;
                state_nxt      = ST_POINT;
              end
              if (auto_r && (pos_r != POS_MAX)) begin
                pos_nxt = pos_r + 4'd1;
              end
            end
            RPT_TEXT: begin
              res_nxt = res_r;
              if (len_r != '0) begin
                idx_nxt   = '0;
                state_nxt = ST_DRAIN_RD;
              end
            end
            default: begin
              res_nxt = res_r;
            end
          endcase
        end
      end
      ST_POINT: begin
        mem_wdata = point_char_r;
        if (!store_full) begin
          mem_we  = 1'b1;
          len_nxt = len_r + LW'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN_OUT;
      end
      ST_DRAIN_OUT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          res_nxt           = '0;
          res_nxt.kind      = RPT_TEXT;
          res_nxt.char_code = rd_data_r;
          res_nxt.last      = drain_last;
          if (drain_last) begin
            len_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      auto_r      <= 1'b0;
      pos_r       <= 4'd0;
      len_r       <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      auto_r      <= auto_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
    end
    res_r        <= res_nxt;
    point_char_r <= point_char_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[len_r[AW-1:0]] <= mem_wdata;
    end
    rd_data_r <= text_mem[idx_r];
  end

endmodule
`default_nettype wire

// ----- hdl/led_driver_command_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat passes the front register, a queue entry and the result register.
// The front end takes one beat per cycle, while the queue is not full, into a two-entry
// queue; a data beat with a point takes an extra point state, set by the single text store
// write port. A stop emits each stored character after a registered store read.
// Synchronous active-low reset empties the queue, the text store and the output register.
module led_driver_command_decoder_top
  import ldcd_pkg::*;
#(
  parameter int TEXT_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // bus_byte
  input  wire logic [1:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // test_mode, fixed_addressing, read_access, display_on, contrast_level,
  // digit_position, segment_mask, char_code, point_mark, zero padding
  output logic [31:0]      out_tdata,
  output logic [2:0]       out_tuser,  // report_kind
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic         point_as_colon_r;
  logic         q_full;
  logic         push;
  ldcd_item_t   push_item;
  logic         pop;
  logic         head_valid;
  ldcd_item_t   head;
  ldcd_result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{31{1'b0}}, point_as_colon_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_as_colon_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      point_as_colon_r <= cfg_pwdata[0];
    end
  end

  ldcd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .point_as_colon (point_as_colon_r),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  ldcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ldcd_back #(
    .TEXT_DEPTH (TEXT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_result (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.last;
  assign out_tdata = {4'b0000, res.point_mark, res.char_code, res.segment_mask,
                      res.digit_position, res.contrast_level, res.display_on,
                      res.read_access, res.fixed_addressing, res.test_mode};

endmodule
`default_nettype wire

// ----- hdl/ldcd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ldcd_checker
  import ldcd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled output beat must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Only text characters come in runs; every other report ends its run.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != RPT_TEXT) |-> out_tlast)
    else $error("non-text report without last");

  // An address command always lands on digits one to eight.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == RPT_ADDR_CMD) |->
      (out_tdata[10:7] != 4'd0) && (out_tdata[10] == 1'b0 || out_tdata[9:7] == 3'd0))
    else $error("address command position out of range");

  // The point mark never takes the unused code.
  a_point_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[27:26] != 2'b11)
    else $error("invalid point mark");

endmodule

bind led_driver_command_decoder_top ldcd_checker u_ldcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ----- bench/led_driver_command_decoder_top_test.sv -----
`timescale 1ns / 1ps
module led_driver_command_decoder_top_test;
  import ldcd_pkg::*;

  localparam int TEXT_DEPTH = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int REG_POINT_AS_COLON = 0;
  localparam int REG_UNUSED = 1;

  typedef struct {
    op_t        op;
    logic [7:0] bus_byte;
  } bus_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bus_event_t   pending_events[$];
  ldcd_result_t expected_reports[$];

  logic [6:0] text_chars [TEXT_DEPTH];
  int         text_count = 0;
  logic       auto_advance = 1'b0;
  logic [3:0] digit_cursor = '0;
  logic       colon_mode = 1'b0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  logic in_took = 1'b0;
  int   quiet_cycles = 0;
  int   error_count = 0;
  int   beats_queued = 0;

  led_driver_command_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [6:0] font_char(input logic [6:0] segs);
    logic [6:0] ch;
    case (segs)
      7'h00: ch = 7'h20;
      7'h20: ch = 7'h27;
      7'h40: ch = 7'h2D;
      7'h3F: ch = 7'h30;
      7'h06: ch = 7'h31;
      7'h5B: ch = 7'h32;
      7'h4F: ch = 7'h33;
      7'h66: ch = 7'h34;
      7'h6D: ch = 7'h35;
      7'h7D: ch = 7'h36;
      7'h07: ch = 7'h37;
      7'h7F: ch = 7'h38;
      7'h6F: ch = 7'h39;
      7'h77: ch = 7'h41;
      7'h7C: ch = 7'h62;
      7'h39: ch = 7'h43;
      7'h5E: ch = 7'h64;
      7'h79: ch = 7'h45;
      7'h71: ch = 7'h46;
      7'h76: ch = 7'h48;
      7'h30: ch = 7'h49;
      7'h0E: ch = 7'h4A;
      7'h38: ch = 7'h4C;
      7'h54: ch = 7'h6E;
      7'h5C: ch = 7'h6F;
      7'h73: ch = 7'h50;
      7'h50: ch = 7'h72;
      7'h78: ch = 7'h74;
      7'h3E: ch = 7'h55;
      7'h0F: ch = 7'h5D;
      7'h08: ch = 7'h5F;
      7'h58: ch = 7'h63;
      7'h74: ch = 7'h68;
      7'h10: ch = 7'h69;
      7'h1C: ch = 7'h75;
      default: ch = CHAR_UNKNOWN;
    endcase
    return ch;
  endfunction

  function automatic void store_text_char(input logic [6:0] ch);
    if (text_count < TEXT_DEPTH) begin
      text_chars[text_count] = ch;
      text_count++;
    end
  endfunction

  function automatic void predict_reports(input op_t op, input logic [7:0] b);
    ldcd_result_t r;
    logic [1:0]   pm;
    r = '0;
    case (op)
      OP_CMD: begin
        if (b[7:6] != 2'b00) begin
          r.last = 1'b1;
          case (b[7:6])
            CMD_TOP_DATA: begin
              r.kind = RPT_DATA_CMD;
              r.test_mode = b[3];
              r.fixed_addressing = b[2];
              r.read_access = b[1];
              auto_advance = ~b[2];
            end
            CMD_TOP_DISP: begin
              r.kind = RPT_DISP_CMD;
              r.display_on = b[3];
              r.contrast_level = b[2:0];
            end
            default: begin
              digit_cursor = {1'b0, b[2:0]} + 4'd1;
              r.kind = RPT_ADDR_CMD;
              r.digit_position = digit_cursor;
            end
          endcase
          expected_reports.push_back(r);
        end
      end
      OP_DATA: begin
        pm = PM_NONE;
        if (b[7]) pm = colon_mode ? PM_COLON : PM_DOT;
        r.kind = RPT_DIGIT;
        r.digit_position = digit_cursor;
        r.segment_mask = b;
        r.char_code = font_char(b[6:0]);
        r.point_mark = pm;
        r.last = 1'b1;
        expected_reports.push_back(r);
        store_text_char(r.char_code);
        if (pm == PM_DOT) store_text_char(CHAR_DOT);
        else if (pm == PM_COLON) store_text_char(CHAR_COLON);
        if (auto_advance && digit_cursor != POS_MAX) digit_cursor++;
      end
      OP_STOP: begin
        for (int k = 0; k < text_count; k++) begin
          r = '0;
          r.kind = RPT_TEXT;
          r.char_code = text_chars[k];
          r.last = (k == text_count - 1);
          expected_reports.push_back(r);
        end
        text_count = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic string describe(input ldcd_result_t r);
    return $sformatf({"kind=%0d test=%0b fixed=%0b read=%0b on=%0b contrast=%0d pos=%0d ",
                      "segs=%02h char=%02h point=%0d last=%0b"},
                     r.kind, r.test_mode, r.fixed_addressing, r.read_access, r.display_on,
                     r.contrast_level, r.digit_position, r.segment_mask, r.char_code,
                     r.point_mark, r.last);
  endfunction

  always @(negedge clk) begin
    bus_event_t ev;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        ev = pending_events.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= ev.bus_byte;
        in_tuser <= ev.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ldcd_result_t got;
    ldcd_result_t want;
    logic         out_took;
    in_took = in_tvalid && in_tready;
    out_took = out_tvalid && out_tready;
    if (rst_n) begin
      if (in_took) predict_reports(op_t'(in_tuser), in_tdata);
      if (out_took) begin
        got = '0;
        got.kind = report_kind_t'(out_tuser);
        got.test_mode = out_tdata[0];
        got.fixed_addressing = out_tdata[1];
        got.read_access = out_tdata[2];
        got.display_on = out_tdata[3];
        got.contrast_level = out_tdata[6:4];
        got.digit_position = out_tdata[10:7];
        got.segment_mask = out_tdata[18:11];
        got.char_code = out_tdata[25:19];
        got.point_mark = out_tdata[27:26];
        got.last = out_tlast;
        if (expected_reports.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result beat: %s", describe(got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10) begin
              $display("result mismatch");
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (in_took || out_took) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_beat(input op_t op, input logic [7:0] b);
    bus_event_t ev;
    ev.op = op;
    ev.bus_byte = b;
    pending_events.push_back(ev);
    beats_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (!(pending_events.size() == 0 && !in_tvalid && expected_reports.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = 3'(idx * 4);
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (idx == REG_POINT_AS_COLON) colon_mode = value[0];
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic queue_random_traffic(input int target);
    int         pick;
    int         digits;
    logic [7:0] b;
    beats_queued = 0;
    while (beats_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_beat(OP_START, 8'($urandom));
        queue_beat(OP_CMD, {CMD_TOP_DATA, 6'($urandom)});
        if ($urandom_range(99) < 70) queue_beat(OP_CMD, {CMD_TOP_ADDR, 6'($urandom)});
        digits = ($urandom_range(99) < 15) ? $urandom_range(10, 20) : $urandom_range(1, 9);
        repeat (digits) begin
          if ($urandom_range(1) == 1) begin
            do b[6:0] = 7'($urandom);
            while (font_char(b[6:0]) == CHAR_UNKNOWN);
            b[7] = 1'($urandom);
          end else begin
            b = 8'($urandom);
          end
          queue_beat(OP_DATA, b);
        end
        queue_beat(OP_STOP, 8'($urandom));
      end else if (pick < 85) begin
        queue_beat(OP_CMD, {CMD_TOP_DISP, 6'($urandom)});
        repeat ($urandom_range(1, 4)) queue_beat(OP_DATA, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) queue_beat(op_t'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 30;
    recv_idle_pct = 64;
    write_register(REG_POINT_AS_COLON, 32'd0);
    queue_beat(OP_START, 8'hFF);
    queue_beat(OP_CMD, 8'h00);
    queue_beat(OP_CMD, 8'h3F);
    queue_beat(OP_CMD, 8'h40);
    queue_beat(OP_CMD, 8'h4E);
    queue_beat(OP_DATA, 8'h5B);
    queue_beat(OP_CMD, 8'h4A);
    queue_beat(OP_CMD, 8'h80);
    queue_beat(OP_CMD, 8'h8F);
    queue_beat(OP_CMD, 8'hC0);
    queue_beat(OP_DATA, 8'h00);
    queue_beat(OP_DATA, 8'hFF);
    queue_beat(OP_DATA, 8'h3F);
    queue_beat(OP_DATA, 8'h55);
    queue_beat(OP_CMD, 8'hC7);
    // Nine writes from position 8 run the cursor into saturation and overflow the text store.
    repeat (9) queue_beat(OP_DATA, 8'h86);
    queue_beat(OP_STOP, 8'h00);
    queue_beat(OP_STOP, 8'hFF);
    wait_drained();
    queue_random_traffic(115);
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 30;
    write_register(REG_POINT_AS_COLON, 32'hFFFF_FFFF);
    write_register(REG_UNUSED, 32'd0);
    queue_beat(OP_DATA, 8'h80);
    queue_beat(OP_DATA, 8'hBF);
    queue_beat(OP_STOP, 8'h00);
    queue_random_traffic(115);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_POINT_AS_COLON, 32'd0);
    queue_random_traffic(60);
    hold_requests++;
    wait_drained();
    queue_random_traffic(60);
    wait_drained();

    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- led_driver_command_decoder_top.f -----
hdl/ldcd_pkg.sv
hdl/ldcd_front.sv
hdl/ldcd_queue.sv
hdl/ldcd_back.sv
hdl/led_driver_command_decoder_top.sv
hdl/ldcd_checker.sv
bench/led_driver_command_decoder_top_test.sv
